[hdl/bdac_pkg.sv]
// Shared constants and control types for the assignment counter.
`default_nettype none

package bdac_pkg;

   localparam int MAX_PERSONS_DEF = 10;
   localparam int MASK_W          = 10;
   localparam int COUNT_W         = 30;
   localparam int PC_W            = 4;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 32;

   localparam logic [COUNT_W-1:0] WAY_MOD      = COUNT_W'(1000000007);
   localparam logic [PC_W-1:0]    PC_RESET_VAL = PC_W'(10);

   // Controller to datapath
   typedef struct packed {
      logic rd_en;      // issue a table read this cycle
      logic rd_self;    // read is the subset's own count (starts the sum)
      logic rd_last;    // final read for this subset: write back after it
      logic pass_start; // a new item was accepted
      logic pass_end;   // all writes of the pass land at this edge
      logic pass_last;  // the pass belonged to the final item
      logic load_rsp;   // move the captured count to the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_busy;   // output register holds a beat that is not taken now
   } status_type;

endpackage

`default_nettype wire

[hdl/bitmask_dp_assignment_count.sv]
// Top level of the assignment counter: sequencer plus count-table datapath.
//
// Counts, modulo 1000000007, the ways to give each of person_count persons a
// different item type. Each req beat carries one item type: tdata[9:0] is the
// mask of persons who may take it, tlast marks the final item type of a problem.
// A one-beat rsp follows the final item, carrying the count in tdata[29:0].
// The csr port loads person_count (values above MAX_PERSONS act as MAX_PERSONS);
// write it only while the block is idle.
//
// Each item makes one pass over the 2^MAX_PERSONS subset table, highest set first,
// one table read per cycle, with the write-back on a separate write port: every
// subset takes one read for its own count plus one per person who may take it.
// Once the final pass ends, the rsp beat is loaded as soon as the output register is free.
// The table needs no clearing sweep: the first pass of a problem treats every
// read as the cleared value, so the block is ready right after reset and right
// after each result. Reset also sets person_count to 10.
// A held rsp beat does not block req: the next problem is worked on meanwhile,
// and its final result waits only if the earlier beat is still not taken.
`default_nettype none

module bitmask_dp_assignment_count #(
   parameter int MAX_PERSONS = bdac_pkg::MAX_PERSONS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [bdac_pkg::PC_W-1:0]        csr_wdata,   // person_count
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bdac_pkg::REQ_DATA_W-1:0]  req_tdata,   // [9:0] person_mask
   input  wire logic                             req_tlast,   // last_item
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [bdac_pkg::RSP_DATA_W-1:0]       rsp_tdata    // [29:0] way_count
);

   bdac_pkg::cmd_type             cmd;
   bdac_pkg::status_type          status;
   logic [MAX_PERSONS-1:0]        rd_addr;
   logic [MAX_PERSONS-1:0]        set_addr;
   logic [bdac_pkg::COUNT_W-1:0]  way_count;

   // Sequencer: walks subsets, issues one table read per cycle
   bdac_ctrl #(
      .MAX_PERSONS (MAX_PERSONS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .person_mask (req_tdata[bdac_pkg::MASK_W-1:0]),
      .last_item   (req_tlast),
      .status      (status),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .set_addr    (set_addr)
   );

   // Table, modular sum, person count and rsp register
   bdac_dp #(
      .MAX_PERSONS (MAX_PERSONS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .set_addr   (set_addr),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .way_count  (way_count)
   );

   // Pad the count to whole bytes
   assign rsp_tdata = bdac_pkg::RSP_DATA_W'(way_count);

endmodule

`default_nettype wire

[hdl/bdac_ctrl.sv]
// Sequencer that walks subsets and their neighbor reads for each item.
`default_nettype none

module bdac_ctrl #(
   parameter int MAX_PERSONS = bdac_pkg::MAX_PERSONS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [bdac_pkg::MASK_W-1:0] person_mask,
   input  wire logic                      last_item,
   input  wire bdac_pkg::status_type      status,
   output bdac_pkg::cmd_type              cmd,
   output logic [MAX_PERSONS-1:0]         rd_addr,
   output logic [MAX_PERSONS-1:0]         set_addr
);

   localparam int WIDE_W = bdac_pkg::MASK_W + MAX_PERSONS;
   localparam logic [MAX_PERSONS-1:0] SET_ONE = MAX_PERSONS'(1);

   typedef enum logic [2:0] {
      IDLE,
      SELF,
      NEIGH,
      DRAIN,
      HOLD
   } state_type;

   state_type              state_ff, state_in;
   logic [MAX_PERSONS-1:0] set_ff, set_in;
   logic [MAX_PERSONS-1:0] rem_ff, rem_in;
   logic [MAX_PERSONS-1:0] takers_ff, takers_in;
   logic                   last_ff, last_in;

   logic [WIDE_W-1:0]      mask_wide;
   logic [MAX_PERSONS-1:0] cand;
   logic [MAX_PERSONS-1:0] low_bit;
   logic [MAX_PERSONS-1:0] rest;

   always_comb begin
      mask_wide = WIDE_W'(person_mask);
      cand      = set_ff & takers_ff;
      low_bit   = rem_ff & (~rem_ff + SET_ONE);
      rest      = rem_ff & (rem_ff - SET_ONE);

      state_in   = state_ff;
      set_in     = set_ff;
      rem_in     = rem_ff;
      takers_in  = takers_ff;
      last_in    = last_ff;
      cmd        = '0;
      rd_addr    = set_ff;
      req_tready = 1'b0;

      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               takers_in      = mask_wide[MAX_PERSONS-1:0];
               last_in        = last_item;
               set_in         = '1;
               cmd.pass_start = 1'b1;
               state_in       = SELF;
            end
         end
         SELF: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_self = 1'b1;
            cmd.rd_last = (cand == '0);
            rem_in      = cand;
            if (cand != '0) begin
               state_in = NEIGH;
            end else if (set_ff == SET_ONE) begin
               state_in = DRAIN;
            end else begin
               set_in = set_ff - SET_ONE;
            end
         end
         NEIGH: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_last = (rest == '0);
            rd_addr     = set_ff ^ low_bit;
            rem_in      = rest;
            if (rest == '0) begin
               if (set_ff == SET_ONE) begin
                  state_in = DRAIN;
               end else begin
                  set_in   = set_ff - SET_ONE;
                  state_in = SELF;
               end
            end
         end
         DRAIN: begin
            cmd.pass_end  = 1'b1;
            cmd.pass_last = last_ff;
            state_in      = last_ff ? HOLD : IDLE;
         end
         HOLD: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   assign set_addr = set_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      set_ff    <= set_in;
      rem_ff    <= rem_in;
      takers_ff <= takers_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

[hdl/bdac_dp.sv]
// Count table, modular accumulator, person count register and output register.
`default_nettype none

module bdac_dp #(
   parameter int MAX_PERSONS = bdac_pkg::MAX_PERSONS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [bdac_pkg::PC_W-1:0]    csr_wdata,
   input  wire bdac_pkg::cmd_type            cmd,
   input  wire logic [MAX_PERSONS-1:0]       rd_addr,
   input  wire logic [MAX_PERSONS-1:0]       set_addr,
   output bdac_pkg::status_type              status,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [bdac_pkg::COUNT_W-1:0]      way_count
);

   localparam int DEPTH = 1 << MAX_PERSONS;
   localparam int CW    = bdac_pkg::COUNT_W;

   logic [CW-1:0] table_mem [DEPTH];

   logic [bdac_pkg::PC_W-1:0] pc_ff;
   logic                      first_ff;

   logic                      tag_valid_ff;
   logic                      tag_self_ff;
   logic                      tag_last_ff;
   logic                      tag_zero_ff;
   logic [MAX_PERSONS-1:0]    tag_set_ff;
   logic [CW-1:0]             rd_data_ff;

   logic [CW-1:0]             acc_ff;
   logic [CW-1:0]             result_ff;
   logic [CW-1:0]             rsp_data_ff;
   logic                      rsp_valid_ff;

   logic [CW-1:0]             operand;
   logic [CW-1:0]             base;
   logic [CW:0]               sum;
   logic [CW-1:0]             acc_next;
   logic [MAX_PERSONS-1:0]    full_set;
   logic                      wr_en;

   always_comb begin
      // Empty set counts one; in the first pass of a problem all else reads zero
      priority if (tag_zero_ff) begin
         operand = CW'(1);
      end else if (first_ff) begin
         operand = '0;
      end else begin
         operand = rd_data_ff;
      end
      base = tag_self_ff ? '0 : acc_ff;
      sum  = {1'b0, base} + {1'b0, operand};
      if (sum >= {1'b0, bdac_pkg::WAY_MOD}) begin
         acc_next = CW'(sum - {1'b0, bdac_pkg::WAY_MOD});
      end else begin
         acc_next = sum[CW-1:0];
      end
      wr_en = tag_valid_ff && tag_last_ff;
      for (int i = 0; i < MAX_PERSONS; i++) begin
         full_set[i] = (i < int'(pc_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
      if (wr_en) begin
         table_mem[tag_set_ff] <= acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= bdac_pkg::PC_RESET_VAL;
         first_ff     <= 1'b1;
         tag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            pc_ff <= csr_wdata;
         end
         if (cmd.pass_end) begin
            first_ff <= cmd.pass_last;
         end
         tag_valid_ff <= cmd.rd_en;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      tag_self_ff <= cmd.rd_self;
      tag_last_ff <= cmd.rd_last;
      tag_zero_ff <= (rd_addr == '0);
      tag_set_ff  <= set_addr;
      if (tag_valid_ff) begin
         acc_ff <= acc_next;
      end
      // Preload one for the empty full set; the pass overwrites it otherwise
      if (cmd.pass_start) begin
         result_ff <= CW'(1);
      end else if (wr_en && (tag_set_ff == full_set)) begin
         result_ff <= acc_next;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign way_count       = rsp_data_ff;

endmodule

`default_nettype wire
